// ----- hdl/ett_pkg.sv -----
// Types and constants shared by the expiring timeout table core.
// Holds the item structs, result kind codes and the age unit's result type.
// No dependencies.
`timescale 1ns / 1ps

package ett_pkg;

    localparam int TIME_W = 24;
    localparam int USER_W = 31;
    localparam int REM_W  = 7;

    // Timeout given to added entries after reset: 30 s in 1/256 s units.
    localparam logic [TIME_W-1:0] JOIN_TIMEOUT_RST = 24'd7680;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef enum logic [1:0] {
        KIND_ADD_OK    = 2'd0,
        KIND_ADD_FULL  = 2'd1,
        KIND_EXPIRED   = 2'd2,
        KIND_TICK_NONE = 2'd3
    } kind_t;

    typedef struct packed {
        logic              command;
        logic [USER_W-1:0] user_id;
        logic [TIME_W-1:0] delta;
    } in_item_t;

    typedef struct packed {
        kind_t             kind;
        logic [USER_W-1:0] expired_user;
        logic [REM_W-1:0]  remaining;
        logic              last;
    } out_item_t;

    typedef struct packed {
        logic              alive;
        logic [TIME_W-1:0] time_left;
    } age_t;

endpackage

// ----- hdl/ett_age_unit.sv -----
// Shared aging unit: subtracts the tick delta from one entry's timeout.
// Wraps on underflow rather than saturating; flags whether the entry survives. Uses ett_pkg.
`timescale 1ns / 1ps

module ett_age_unit
    import ett_pkg::*;
(
    input  logic [TIME_W-1:0] time_left,
    input  logic [TIME_W-1:0] delta,
    output age_t              age
);

    logic [TIME_W:0] diff;

    // The extra top bit is the borrow: set when delta exceeds the timeout.
    assign diff = {1'b0, time_left} - {1'b0, delta};

    always_comb
    begin
        age.alive     = !diff[TIME_W] && (diff[TIME_W-1:0] != '0);
        age.time_left = diff[TIME_W-1:0];
    end

endmodule

// ----- hdl/expiring_timeout_table_core.sv -----
// Top level of the expiring timeout table: sequencer, entry memories,
// expired-id buffer and output register. Uses ett_pkg and ett_age_unit.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake            Payload
//  --------  ---------  -------------------  ----------------------------------
//  in        sink       in_valid / in_stall  in_item  (command, user_id, delta)
//  out       source     out_valid/out_stall  out_item (kind, expired_user,
//                                                      remaining, last)
//  cfg       sink       cfg_valid/cfg_ready  cfg_data (join_timeout)
//
//  An add writes its entry in the accept cycle if the table is not full; ST_RESP
//  then loads its result into the output register once that register is free.
//  A tick is accepted, walks the table in ST_WALK, then gives either a single
//  "none expired" result from ST_RESP or, for each expired entry, a read in
//  ST_EMIT_RD and a load into the output register in ST_EMIT_WR.
//  The walk visits one entry per cycle, set by the single read port of the
//  entry memory and the one shared subtractor.
//  Reset clears the count, the sequencer and the output valid; the entry
//  memories hold no reset value and are only read below the count.
//  A stall on the output holds the finished item in the output register; the
//  sequencer waits for it to leave before it loads the next result.

module expiring_timeout_table_core
    import ett_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
)
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              in_valid,
    output logic              in_stall,
    input  in_item_t          in_item,

    output logic              out_valid,
    input  logic              out_stall,
    output out_item_t         out_item,

    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [TIME_W-1:0] cfg_data
);

    // Index width covers the table; count width can also hold the depth itself.
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_WALK    = 5'b00010,
        ST_EMIT_RD = 5'b00100,
        ST_EMIT_WR = 5'b01000,
        ST_RESP    = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [TIME_W-1:0] join_timeout_reg, join_timeout_next;
    logic [TIME_W-1:0] delta_reg, delta_next;
    logic [CNT_W-1:0]  rd_cnt_reg, rd_cnt_next;
    logic              rd_pend_reg, rd_pend_next;
    logic [CNT_W-1:0]  keep_reg, keep_next;
    logic [CNT_W-1:0]  ngone_reg, ngone_next;
    logic [CNT_W-1:0]  emit_idx_reg, emit_idx_next;
    kind_t             kind_reg, kind_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_item_reg, out_item_next;

    // Entry memories (user id and remaining time) and the expired-id buffer.
    logic [USER_W-1:0] user_mem [TABLE_DEPTH];
    logic [TIME_W-1:0] time_mem [TABLE_DEPTH];
    logic [USER_W-1:0] gone_mem [TABLE_DEPTH];

    logic [USER_W-1:0] rd_user_reg;
    logic [TIME_W-1:0] rd_time_reg;
    logic [USER_W-1:0] gone_user_reg;

    logic              mem_wr_en;
    logic [IDX_W-1:0]  mem_wr_addr;
    logic [USER_W-1:0] mem_wr_user;
    logic [TIME_W-1:0] mem_wr_time;
    logic              mem_rd_en;
    logic              gone_wr_en;
    logic              gone_rd_en;

    logic              out_free;
    logic              emit_last;
    age_t              age;

    ett_age_unit u_age
    (
        .time_left (rd_time_reg),
        .delta     (delta_reg),
        .age       (age)
    );

    // The output register can take a new item when it is empty or draining now.
    assign out_free  = !out_valid_reg || !out_stall;
    assign emit_last = (emit_idx_reg + CNT_W'(1)) == ngone_reg;

    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        join_timeout_next = join_timeout_reg;
        delta_next        = delta_reg;
        rd_cnt_next       = rd_cnt_reg;
        rd_pend_next      = rd_pend_reg;
        keep_next         = keep_reg;
        ngone_next        = ngone_reg;
        emit_idx_next     = emit_idx_reg;
        kind_next         = kind_reg;
        out_valid_next    = out_valid_reg && out_stall;
        out_item_next     = out_item_reg;

        mem_wr_en   = 1'b0;
        mem_wr_addr = '0;
        mem_wr_user = '0;
        mem_wr_time = '0;
        mem_rd_en   = 1'b0;
        gone_wr_en  = 1'b0;
        gone_rd_en  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cfg_valid)
                begin
                    join_timeout_next = cfg_data;
                end
                if (in_valid)
                begin
                    if (in_item.command == CMD_ADD)
                    begin
                        if (cnt_reg < DEPTH_CNT)
                        begin
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = cnt_reg[IDX_W-1:0];
                            mem_wr_user = in_item.user_id;
                            mem_wr_time = join_timeout_reg;
                            cnt_next    = cnt_reg + CNT_W'(1);
                            kind_next   = KIND_ADD_OK;
                        end
                        else
                        begin
                            kind_next = KIND_ADD_FULL;
                        end
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        delta_next   = in_item.delta;
                        rd_cnt_next  = '0;
                        rd_pend_next = 1'b0;
                        keep_next    = '0;
                        ngone_next   = '0;
                        state_next   = ST_WALK;
                    end
                end
            end

            ST_WALK:
            begin
                // Age the entry read last cycle; survivors move down to keep.
                if (rd_pend_reg)
                begin
                    if (age.alive)
                    begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = keep_reg[IDX_W-1:0];
                        mem_wr_user = rd_user_reg;
                        mem_wr_time = age.time_left;
                        keep_next   = keep_reg + CNT_W'(1);
                    end
                    else
                    begin
                        gone_wr_en = 1'b1;
                        ngone_next = ngone_reg + CNT_W'(1);
                    end
                end
                // Keep reading ahead; keep never passes the read pointer.
                if (rd_cnt_reg != cnt_reg)
                begin
                    mem_rd_en    = 1'b1;
                    rd_cnt_next  = rd_cnt_reg + CNT_W'(1);
                    rd_pend_next = 1'b1;
                end
                else
                begin
                    rd_pend_next = 1'b0;
                    if (!rd_pend_reg)
                    begin
                        cnt_next = keep_reg;
                        if (ngone_reg == '0)
                        begin
                            kind_next  = KIND_TICK_NONE;
                            state_next = ST_RESP;
                        end
                        else
                        begin
                            emit_idx_next = '0;
                            state_next    = ST_EMIT_RD;
                        end
                    end
                end
            end

            ST_EMIT_RD:
            begin
                gone_rd_en = 1'b1;
                state_next = ST_EMIT_WR;
            end

            ST_EMIT_WR:
            begin
                if (out_free)
                begin
                    out_valid_next             = 1'b1;
                    out_item_next.kind         = KIND_EXPIRED;
                    out_item_next.expired_user = gone_user_reg;
                    out_item_next.remaining    = REM_W'(cnt_reg);
                    out_item_next.last         = emit_last;
                    emit_idx_next              = emit_idx_reg + CNT_W'(1);
                    state_next                 = emit_last ? ST_IDLE : ST_EMIT_RD;
                end
            end

            ST_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next             = 1'b1;
                    out_item_next.kind         = kind_reg;
                    out_item_next.expired_user = '0;
                    out_item_next.remaining    = REM_W'(cnt_reg);
                    out_item_next.last         = 1'b1;
                    state_next                 = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            join_timeout_reg <= JOIN_TIMEOUT_RST;
            rd_cnt_reg       <= '0;
            rd_pend_reg      <= 1'b0;
            keep_reg         <= '0;
            ngone_reg        <= '0;
            emit_idx_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            join_timeout_reg <= join_timeout_next;
            rd_cnt_reg       <= rd_cnt_next;
            rd_pend_reg      <= rd_pend_next;
            keep_reg         <= keep_next;
            ngone_reg        <= ngone_next;
            emit_idx_reg     <= emit_idx_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        delta_reg    <= delta_next;
        kind_reg     <= kind_next;
        out_item_reg <= out_item_next;
    end

    // Entry memories: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            user_mem[mem_wr_addr] <= mem_wr_user;
            time_mem[mem_wr_addr] <= mem_wr_time;
        end
        if (mem_rd_en)
        begin
            rd_user_reg <= user_mem[rd_cnt_reg[IDX_W-1:0]];
            rd_time_reg <= time_mem[rd_cnt_reg[IDX_W-1:0]];
        end
    end

    // Expired ids are parked here until the walk knows the final count.
    always_ff @(posedge clk)
    begin
        if (gone_wr_en)
        begin
            gone_mem[ngone_reg[IDX_W-1:0]] <= rd_user_reg;
        end
        if (gone_rd_en)
        begin
            gone_user_reg <= gone_mem[emit_idx_reg[IDX_W-1:0]];
        end
    end

    // The count never exceeds the table depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= DEPTH_CNT)
        else $error("entry count above table depth");

    // Every entry read during a walk is either kept, expired or still in flight.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |->
        ({1'b0, keep_reg} + {1'b0, ngone_reg} + (CNT_W+1)'(rd_pend_reg))
            == {1'b0, rd_cnt_reg})
        else $error("walk bookkeeping lost an entry");

    // Expired results are only drawn from entries that were parked.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT_RD || state_reg == ST_EMIT_WR) |->
        (emit_idx_reg < ngone_reg))
        else $error("emit index past expired count");

    // A new result is only loaded by the result-producing states.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |->
        ($past(state_reg) == ST_RESP || $past(state_reg) == ST_EMIT_WR))
        else $error("output loaded outside a result state");

    // Loading the final result of an item returns the sequencer to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT_WR && out_free && emit_last) |=>
        (state_reg == ST_IDLE))
        else $error("sequencer did not finish after last result");

endmodule
